// ----- design/cascade_pid_controller_unit_assert.svh -----
// Assertion macros used by the checker of the cascade PID controller.
`ifndef CASCADE_PID_CONTROLLER_UNIT_ASSERT_SVH
`define CASCADE_PID_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPID_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPID_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/cpid_pkg.sv -----
// Shared types, constants and codes of the cascade PID controller.
`default_nettype none

package cpid_pkg;

  // Parameter defaults.
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int INTEGRAL_BITS_DEF = 24;

  // Fixed field widths.
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 23;
  localparam int DRIVE_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Reset value of the integral clamp.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_KP       = 4'd0,
    REG_OUTER_KI       = 4'd1,
    REG_OUTER_KD       = 4'd2,
    REG_INNER_KP       = 4'd3,
    REG_INNER_KI       = 4'd4,
    REG_INNER_KD       = 4'd5,
    REG_INTEGRAL_LIMIT = 4'd6,
    REG_LOOP_MODE      = 4'd7
  } reg_idx_e;

  // Loop mode codes.
  localparam logic MODE_SINGLE  = 1'b0;
  localparam logic MODE_CASCADE = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ADD,
    ST_SAT,
    ST_WRITE
  } state_e;

  // Datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ERR,
    CMD_MUL_P,
    CMD_MUL_I,
    CMD_MUL_D,
    CMD_ADD,
    CMD_SAT,
    CMD_WRITE
  } cmd_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    cmd_e op;
    logic inner;
  } cmd_t;

  // Configuration register contents.
  typedef struct packed {
    logic [GAIN_W-1:0]  outer_kp;
    logic [GAIN_W-1:0]  outer_ki;
    logic [GAIN_W-1:0]  outer_kd;
    logic [GAIN_W-1:0]  inner_kp;
    logic [GAIN_W-1:0]  inner_ki;
    logic [GAIN_W-1:0]  inner_kd;
    logic [LIMIT_W-1:0] integral_limit;
    logic               loop_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/cpid_if.sv -----
// Channel interfaces of the cascade PID controller: input, result and configuration.
`default_nettype none

// Input channel: one control tick per word.
interface cpid_in_if #(
  parameter int SAMPLE_BITS = cpid_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] inner_measured;
  logic signed [SAMPLE_BITS-1:0] outer_measured;
  logic signed [SAMPLE_BITS-1:0] outer_target;

  modport source (
    output valid, inner_measured, outer_measured, outer_target,
    input  ready
  );
  modport sink (
    input  valid, inner_measured, outer_measured, outer_target,
    output ready
  );
endinterface

// Result channel: one word per tick.
interface cpid_out_if #(
  parameter int SAMPLE_BITS = cpid_pkg::SAMPLE_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [cpid_pkg::DRIVE_W-1:0] drive;
  logic signed [SAMPLE_BITS-1:0]      outer_drive;

  modport source (
    output valid, drive, outer_drive,
    input  ready
  );
  modport sink (
    input  valid, drive, outer_drive,
    output ready
  );
endinterface

// Configuration write channel.
interface cpid_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cpid_pkg::CFG_IDX_W-1:0]  index;
  logic [cpid_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/cpid_cfg.sv -----
// Configuration register file of the cascade PID controller.
`default_nettype none

module cpid_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_valid_i,
  output logic                                 wr_ready_o,
  input  wire logic [cpid_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  wire logic [cpid_pkg::CFG_DATA_W-1:0] wr_data_i,
  output cpid_pkg::cfg_t                       cfg_o
);

  cpid_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outer_kp       <= '0;
      cfg_q.outer_ki       <= '0;
      cfg_q.outer_kd       <= '0;
      cfg_q.inner_kp       <= '0;
      cfg_q.inner_ki       <= '0;
      cfg_q.inner_kd       <= '0;
      cfg_q.integral_limit <= cpid_pkg::LIMIT_RESET;
      cfg_q.loop_mode      <= cpid_pkg::MODE_CASCADE;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        cpid_pkg::REG_OUTER_KP: begin
          cfg_q.outer_kp <= wr_data_i[cpid_pkg::GAIN_W-1:0];
        end
        cpid_pkg::REG_OUTER_KI: begin
          cfg_q.outer_ki <= wr_data_i[cpid_pkg::GAIN_W-1:0];
        end
        cpid_pkg::REG_OUTER_KD: begin
          cfg_q.outer_kd <= wr_data_i[cpid_pkg::GAIN_W-1:0];
        end
        cpid_pkg::REG_INNER_KP: begin
          cfg_q.inner_kp <= wr_data_i[cpid_pkg::GAIN_W-1:0];
        end
        cpid_pkg::REG_INNER_KI: begin
          cfg_q.inner_ki <= wr_data_i[cpid_pkg::GAIN_W-1:0];
        end
        cpid_pkg::REG_INNER_KD: begin
          cfg_q.inner_kd <= wr_data_i[cpid_pkg::GAIN_W-1:0];
        end
        cpid_pkg::REG_INTEGRAL_LIMIT: begin
          cfg_q.integral_limit <= wr_data_i[cpid_pkg::LIMIT_W-1:0];
        end
        cpid_pkg::REG_LOOP_MODE: begin
          cfg_q.loop_mode <= wr_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/cpid_ctrl.sv -----
// Sequencing state machine of the cascade PID controller.
`default_nettype none

module cpid_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire logic       loop_mode_i,
  output cpid_pkg::cmd_t  cmd_o
);

  cpid_pkg::state_e state_q, state_d;
  logic             inner_q, inner_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             do_write;

  // The result register may be loaded when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;
  assign do_write = (state_q == cpid_pkg::ST_WRITE) && out_free;

  // Next state and loop selection.
  always_comb begin
    state_d = state_q;
    inner_d = inner_q;
    case (state_q)
      cpid_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = cpid_pkg::ST_ERR;
          inner_d = 1'b0;
        end
      end
      cpid_pkg::ST_ERR:   state_d = cpid_pkg::ST_MUL_P;
      cpid_pkg::ST_MUL_P: state_d = cpid_pkg::ST_MUL_I;
      cpid_pkg::ST_MUL_I: state_d = cpid_pkg::ST_MUL_D;
      cpid_pkg::ST_MUL_D: state_d = cpid_pkg::ST_ADD;
      cpid_pkg::ST_ADD:   state_d = cpid_pkg::ST_SAT;
      cpid_pkg::ST_SAT: begin
        // After the outer loop, run the inner loop in cascade mode.
        if (!inner_q && (loop_mode_i == cpid_pkg::MODE_CASCADE)) begin
          state_d = cpid_pkg::ST_ERR;
          inner_d = 1'b1;
        end else begin
          state_d = cpid_pkg::ST_WRITE;
        end
      end
      cpid_pkg::ST_WRITE: begin
        if (out_free) begin
          state_d = cpid_pkg::ST_IDLE;
        end
      end
      default: state_d = cpid_pkg::ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    in_ready_o  = (state_q == cpid_pkg::ST_IDLE);
    out_valid_o = out_valid_q;
    cmd_o.inner = inner_q;
    case (state_q)
      cpid_pkg::ST_IDLE: begin
        cmd_o.op = in_valid_i ? cpid_pkg::CMD_LOAD : cpid_pkg::CMD_NONE;
      end
      cpid_pkg::ST_ERR:   cmd_o.op = cpid_pkg::CMD_ERR;
      cpid_pkg::ST_MUL_P: cmd_o.op = cpid_pkg::CMD_MUL_P;
      cpid_pkg::ST_MUL_I: cmd_o.op = cpid_pkg::CMD_MUL_I;
      cpid_pkg::ST_MUL_D: cmd_o.op = cpid_pkg::CMD_MUL_D;
      cpid_pkg::ST_ADD:   cmd_o.op = cpid_pkg::CMD_ADD;
      cpid_pkg::ST_SAT:   cmd_o.op = cpid_pkg::CMD_SAT;
      cpid_pkg::ST_WRITE: begin
        cmd_o.op = do_write ? cpid_pkg::CMD_WRITE : cpid_pkg::CMD_NONE;
      end
      default: cmd_o.op = cpid_pkg::CMD_NONE;
    endcase
  end

  // Result valid flag: set on load, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (do_write) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpid_pkg::ST_IDLE;
      inner_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inner_q     <= inner_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/cpid_dp.sv -----
// Datapath of the cascade PID controller: loop state, shared multiplier, saturation.
`default_nettype none

module cpid_dp #(
  parameter int SAMPLE_BITS   = cpid_pkg::SAMPLE_BITS_DEF,
  parameter int INTEGRAL_BITS = cpid_pkg::INTEGRAL_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire cpid_pkg::cmd_t                       cmd_i,
  input  wire cpid_pkg::cfg_t                       cfg_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        inner_measured_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        outer_measured_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        outer_target_i,
  output logic signed [cpid_pkg::DRIVE_W-1:0]       drive_o,
  output logic signed [SAMPLE_BITS-1:0]             outer_drive_o
);

  localparam int E_W    = SAMPLE_BITS + 1;
  localparam int D_W    = SAMPLE_BITS + 2;
  localparam int OP_W   = (INTEGRAL_BITS > D_W) ? INTEGRAL_BITS : D_W;
  localparam int G_W    = cpid_pkg::GAIN_W + 1;
  localparam int PROD_W = OP_W + G_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ACC_W  = ((INTEGRAL_BITS > E_W) ? INTEGRAL_BITS : E_W) + 1;
  localparam int CMP_W  = (ACC_W > cpid_pkg::LIMIT_W + 1) ? ACC_W : cpid_pkg::LIMIT_W + 1;
  localparam int DW     = cpid_pkg::DRIVE_W;

  localparam longint INT_HI_L   = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
  localparam longint SAMP_HI_L  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint DRIVE_HI_L = (longint'(1) <<< (DW - 1)) - 1;

  localparam logic signed [CMP_W-1:0] INT_HI   = CMP_W'(INT_HI_L);
  localparam logic signed [CMP_W-1:0] INT_LO   = CMP_W'(-INT_HI_L - 1);
  localparam logic signed [SUM_W-1:0] SAMP_HI  = SUM_W'(SAMP_HI_L);
  localparam logic signed [SUM_W-1:0] SAMP_LO  = SUM_W'(-SAMP_HI_L - 1);
  localparam logic signed [SUM_W-1:0] DRIVE_HI = SUM_W'(DRIVE_HI_L);
  localparam logic signed [SUM_W-1:0] DRIVE_LO = SUM_W'(-DRIVE_HI_L - 1);

  // Latched input samples.
  logic signed [SAMPLE_BITS-1:0]   inner_meas_q, outer_meas_q, outer_tgt_q;
  // Loop state.
  logic signed [E_W-1:0]           outer_prev_q, inner_prev_q;
  logic signed [INTEGRAL_BITS-1:0] outer_int_q, inner_int_q;
  // Working registers of the running loop.
  logic signed [E_W-1:0]           err_q;
  logic signed [D_W-1:0]           diff_q;
  logic signed [INTEGRAL_BITS-1:0] integ_q;
  logic signed [PROD_W-1:0]        prod_q;
  logic signed [SUM_W-1:0]         sum_q;
  logic signed [SAMPLE_BITS-1:0]   outer_y_q;
  logic signed [DW-1:0]            inner_y_q;
  // Result register.
  logic signed [DW-1:0]            drive_q;
  logic signed [SAMPLE_BITS-1:0]   outer_drive_q;

  logic signed [SAMPLE_BITS-1:0]   meas, tgt;
  logic signed [E_W-1:0]           prev, err_d;
  logic signed [INTEGRAL_BITS-1:0] integ_old, integ_d;
  logic signed [D_W-1:0]           diff_d;
  logic signed [ACC_W-1:0]         acc_sum;
  logic signed [CMP_W-1:0]         acc_ext, lim_ext, lim_eff, acc_clamped;
  logic [cpid_pkg::GAIN_W-1:0]     gain;
  logic signed [G_W-1:0]           gain_s;
  logic signed [OP_W-1:0]          op_s;
  logic signed [PROD_W-1:0]        prod_d;
  logic signed [SUM_W-1:0]         sum_acc;
  logic signed [SAMPLE_BITS-1:0]   sat_samp;
  logic signed [DW-1:0]            sat_drive;

  // Error, derivative term and clamped integral of the selected loop.
  always_comb begin
    meas      = cmd_i.inner ? inner_meas_q : outer_meas_q;
    tgt       = cmd_i.inner ? outer_y_q : outer_tgt_q;
    prev      = cmd_i.inner ? inner_prev_q : outer_prev_q;
    integ_old = cmd_i.inner ? inner_int_q : outer_int_q;
    err_d     = E_W'(meas) - E_W'(tgt);
    diff_d    = D_W'(err_d) - D_W'(prev);
    acc_sum   = ACC_W'(integ_old) + ACC_W'(err_d);
    acc_ext   = CMP_W'(acc_sum);
    lim_ext   = signed'(CMP_W'(cfg_i.integral_limit));
    lim_eff   = (lim_ext > INT_HI) ? INT_HI : lim_ext;
    if (acc_ext > lim_eff) begin
      acc_clamped = lim_eff;
    end else if (acc_ext < INT_LO) begin
      acc_clamped = INT_LO;
    end else begin
      acc_clamped = acc_ext;
    end
    integ_d = INTEGRAL_BITS'(acc_clamped);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.op)
      cpid_pkg::CMD_MUL_I: begin
        gain = cmd_i.inner ? cfg_i.inner_ki : cfg_i.outer_ki;
        op_s = OP_W'(integ_q);
      end
      cpid_pkg::CMD_MUL_D: begin
        gain = cmd_i.inner ? cfg_i.inner_kd : cfg_i.outer_kd;
        op_s = OP_W'(diff_q);
      end
      default: begin
        gain = cmd_i.inner ? cfg_i.inner_kp : cfg_i.outer_kp;
        op_s = OP_W'(err_q);
      end
    endcase
    gain_s = signed'({1'b0, gain});
    prod_d = PROD_W'(gain_s) * PROD_W'(op_s);
  end

  // Running sum and output saturation.
  always_comb begin
    sum_acc = sum_q + SUM_W'(prod_q);
    if (sum_q > SAMP_HI) begin
      sat_samp = SAMPLE_BITS'(SAMP_HI);
    end else if (sum_q < SAMP_LO) begin
      sat_samp = SAMPLE_BITS'(SAMP_LO);
    end else begin
      sat_samp = SAMPLE_BITS'(sum_q);
    end
    if (sum_q > DRIVE_HI) begin
      sat_drive = DW'(DRIVE_HI);
    end else if (sum_q < DRIVE_LO) begin
      sat_drive = DW'(DRIVE_LO);
    end else begin
      sat_drive = DW'(sum_q);
    end
  end

  // Loop state, cleared by reset and updated once per loop run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_prev_q <= '0;
      inner_prev_q <= '0;
      outer_int_q  <= '0;
      inner_int_q  <= '0;
    end else if (cmd_i.op == cpid_pkg::CMD_ERR) begin
      if (cmd_i.inner) begin
        inner_prev_q <= err_d;
        inner_int_q  <= integ_d;
      end else begin
        outer_prev_q <= err_d;
        outer_int_q  <= integ_d;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cpid_pkg::CMD_LOAD: begin
        inner_meas_q <= inner_measured_i;
        outer_meas_q <= outer_measured_i;
        outer_tgt_q  <= outer_target_i;
      end
      cpid_pkg::CMD_ERR: begin
        err_q   <= err_d;
        diff_q  <= diff_d;
        integ_q <= integ_d;
      end
      cpid_pkg::CMD_MUL_P: begin
        prod_q <= prod_d;
      end
      cpid_pkg::CMD_MUL_I: begin
        prod_q <= prod_d;
        sum_q  <= SUM_W'(prod_q);
      end
      cpid_pkg::CMD_MUL_D: begin
        prod_q <= prod_d;
        sum_q  <= sum_acc;
      end
      cpid_pkg::CMD_ADD: begin
        sum_q <= sum_acc;
      end
      cpid_pkg::CMD_SAT: begin
        if (cmd_i.inner) begin
          inner_y_q <= sat_drive;
        end else begin
          outer_y_q <= sat_samp;
        end
      end
      cpid_pkg::CMD_WRITE: begin
        drive_q       <= (cfg_i.loop_mode == cpid_pkg::MODE_CASCADE) ?
                         inner_y_q : DW'(outer_y_q);
        outer_drive_q <= outer_y_q;
      end
      default: begin
      end
    endcase
  end

  assign drive_o       = drive_q;
  assign outer_drive_o = outer_drive_q;

endmodule

`default_nettype wire

// ----- design/cascade_pid_controller_unit.sv -----
// Top level of the cascade PID controller.
// Each accepted input word is one control tick. The outer loop and, in cascade
// mode, the inner loop each run these steps: error and clamped integral, three
// multiplies by the gains on one shared multiplier (each product registered),
// a final add, and saturation. The result register is then loaded once it is
// empty or being drained, and the block is ready again the cycle after. No new
// word is taken until the last one is in the result register. In cascade mode,
// the shared multiplier serves all six products. The input side is open again
// while a finished result still waits in the result register; the next result
// waits for that register to drain. Configuration writes are taken in any cycle
// and must only be issued while the block is idle.
`default_nettype none

module cascade_pid_controller_unit #(
  parameter int SAMPLE_BITS   = cpid_pkg::SAMPLE_BITS_DEF,
  parameter int INTEGRAL_BITS = cpid_pkg::INTEGRAL_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpid_in_if.sink   in_i,
  cpid_out_if.source out_o,
  cpid_cfg_if.sink  cfg_i
);

  cpid_pkg::cfg_t cfg;
  cpid_pkg::cmd_t cmd;

  logic signed [SAMPLE_BITS-1:0]         inner_measured, outer_measured, outer_target;
  logic signed [SAMPLE_BITS-1:0]         outer_drive;
  logic signed [cpid_pkg::DRIVE_W-1:0]   drive;

  assign inner_measured = in_i.inner_measured;
  assign outer_measured = in_i.outer_measured;
  assign outer_target   = in_i.outer_target;
  assign out_o.drive       = drive;
  assign out_o.outer_drive = outer_drive;

  // Configuration registers.
  cpid_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Sequencer.
  cpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .loop_mode_i (cfg.loop_mode),
    .cmd_o       (cmd)
  );

  // Arithmetic and loop state.
  cpid_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .inner_measured_i (inner_measured),
    .outer_measured_i (outer_measured),
    .outer_target_i   (outer_target),
    .drive_o          (drive),
    .outer_drive_o    (outer_drive)
  );

endmodule

`default_nettype wire

// ----- design/cpid_checker.sv -----
// Port-level checker of the cascade PID controller and its bind to the top level.
`default_nettype none
`include "cascade_pid_controller_unit_assert.svh"

module cpid_checker #(
  parameter int SAMPLE_BITS = cpid_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [cpid_pkg::DRIVE_W-1:0]      drive_i,
  input wire logic [SAMPLE_BITS-1:0]            outer_drive_i
);

  // A word in progress closes the input side at once.
  `CPID_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A fresh result appears just as the input side reopens after being busy.
  `CPID_ASSERT_IMPL(a_result_ends_tick, clk_i, rst_ni, $rose(out_valid_i), in_ready_i && !$past(in_ready_i))

  // A stalled result word holds.
  `CPID_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(drive_i) && $stable(outer_drive_i))

endmodule

bind cascade_pid_controller_unit cpid_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .drive_i       (out_o.drive),
  .outer_drive_i (out_o.outer_drive)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench of the cascade PID controller: directed and random ticks.
`timescale 1ns / 100ps

module tb_top;

  localparam int SAMPLE_BITS = cpid_pkg::SAMPLE_BITS_DEF;
  localparam int INTEG_BITS  = cpid_pkg::INTEGRAL_BITS_DEF;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 800000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // State that one loop carries from tick to tick.
  typedef struct {
    logic signed [SAMPLE_BITS:0]   prev_err;
    logic signed [INTEG_BITS-1:0]  integ;
  } loop_state_t;

  // One result word as the block should deliver it.
  typedef struct {
    logic signed [cpid_pkg::DRIVE_W-1:0] drive;
    logic signed [SAMPLE_BITS-1:0]       outer_drive;
  } drive_word_t;

  logic clk;
  logic rst_n;

  cpid_in_if  in_ch ();
  cpid_out_if out_ch ();
  cpid_cfg_if cfg_ch ();

  cascade_pid_controller_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Shadow copy of the registers and loop state.
  cpid_pkg::cfg_t shadow_cfg;
  loop_state_t    outer_st;
  loop_state_t    inner_st;
  drive_word_t    pending_drives[$];

  int mismatches;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int track_sp;

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure, held off while reset is asserted.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic longint clamp_signed(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic sample_t sat_sample(longint v);
    longint c;
    c = clamp_signed(v, SAMPLE_BITS);
    return c[SAMPLE_BITS-1:0];
  endfunction

  // One positional PID update: error, clamped integral, and the raw sum of terms.
  function automatic longint pid_update(inout loop_state_t st, input longint meas,
                                        input longint tgt,
                                        input logic [cpid_pkg::GAIN_W-1:0] kp,
                                        input logic [cpid_pkg::GAIN_W-1:0] ki,
                                        input logic [cpid_pkg::GAIN_W-1:0] kd);
    longint err;
    longint acc;
    longint lim;
    longint hi;
    longint lo;
    longint kpl;
    longint kil;
    longint kdl;
    longint y;
    err = meas - tgt;
    hi  = (longint'(1) << (INTEG_BITS - 1)) - 1;
    lo  = -hi - 1;
    lim = longint'(shadow_cfg.integral_limit);
    if (lim > hi) lim = hi;
    acc = longint'(st.integ) + err;
    if (acc > lim) acc = lim;
    if (acc < lo) acc = lo;
    kpl = kp;
    kil = ki;
    kdl = kd;
    y = kpl * err + kil * acc + kdl * (err - longint'(st.prev_err));
    st.integ    = acc[INTEG_BITS-1:0];
    st.prev_err = err[SAMPLE_BITS:0];
    return y;
  endfunction

  // Work out the result of one accepted tick and queue it.
  function automatic void predict_tick(sample_t im, sample_t om, sample_t ot);
    longint outer_y;
    longint drv;
    drive_word_t w;
    outer_y = clamp_signed(pid_update(outer_st, longint'(om), longint'(ot),
                                      shadow_cfg.outer_kp, shadow_cfg.outer_ki,
                                      shadow_cfg.outer_kd), SAMPLE_BITS);
    if (shadow_cfg.loop_mode == cpid_pkg::MODE_CASCADE) begin
      drv = clamp_signed(pid_update(inner_st, longint'(im), outer_y,
                                    shadow_cfg.inner_kp, shadow_cfg.inner_ki,
                                    shadow_cfg.inner_kd), cpid_pkg::DRIVE_W);
    end else begin
      drv = outer_y;
    end
    w.drive       = drv[cpid_pkg::DRIVE_W-1:0];
    w.outer_drive = outer_y[SAMPLE_BITS-1:0];
    pending_drives.push_back(w);
  endfunction

  function automatic void apply_reg(logic [cpid_pkg::CFG_IDX_W-1:0] idx,
                                    logic [cpid_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cpid_pkg::REG_OUTER_KP: shadow_cfg.outer_kp = data[cpid_pkg::GAIN_W-1:0];
      cpid_pkg::REG_OUTER_KI: shadow_cfg.outer_ki = data[cpid_pkg::GAIN_W-1:0];
      cpid_pkg::REG_OUTER_KD: shadow_cfg.outer_kd = data[cpid_pkg::GAIN_W-1:0];
      cpid_pkg::REG_INNER_KP: shadow_cfg.inner_kp = data[cpid_pkg::GAIN_W-1:0];
      cpid_pkg::REG_INNER_KI: shadow_cfg.inner_ki = data[cpid_pkg::GAIN_W-1:0];
      cpid_pkg::REG_INNER_KD: shadow_cfg.inner_kd = data[cpid_pkg::GAIN_W-1:0];
      cpid_pkg::REG_INTEGRAL_LIMIT: begin
        shadow_cfg.integral_limit = data[cpid_pkg::LIMIT_W-1:0];
      end
      cpid_pkg::REG_LOOP_MODE: shadow_cfg.loop_mode = data[0];
      default: begin
        // Writes to unused indexes leave every register unchanged.
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  // Result checker: a word is taken at the rising edge after a negedge with valid and ready.
  always @(negedge clk) begin
    drive_word_t w;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_drives.size() == 0) begin
        flag_mismatch($sformatf("unexpected word drive=%0d outer_drive=%0d",
                                out_ch.drive, out_ch.outer_drive));
      end else begin
        w = pending_drives.pop_front();
        if (out_ch.drive !== w.drive)
          flag_mismatch($sformatf("drive got %0d want %0d", out_ch.drive, w.drive));
        if (out_ch.outer_drive !== w.outer_drive)
          flag_mismatch($sformatf("outer_drive got %0d want %0d",
                                  out_ch.outer_drive, w.outer_drive));
      end
    end
  end

  // Send one tick, with random idle cycles ahead of it.
  task automatic send_tick(input sample_t im, input sample_t om, input sample_t ot);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.inner_measured <= im;
    in_ch.outer_measured <= om;
    in_ch.outer_target   <= ot;
    do begin
      @(negedge clk);
      taken = (in_ch.ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    predict_tick(im, om, ot);
  endtask

  // Write one register; the channel is left idle for a cycle afterwards.
  task automatic write_reg(input logic [cpid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cpid_pkg::CFG_DATA_W-1:0] data);
    bit taken;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do begin
      @(negedge clk);
      taken = (cfg_ch.ready === 1'b1);
      @(posedge clk);
    end while (!taken);
    apply_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [cpid_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return cpid_pkg::GAIN_W'($urandom());
      default: return cpid_pkg::GAIN_W'($urandom_range(8));
    endcase
  endfunction

  function automatic logic [cpid_pkg::LIMIT_W-1:0] pick_limit();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return cpid_pkg::LIMIT_W'($urandom());
      default: return cpid_pkg::LIMIT_W'($urandom_range(5000));
    endcase
  endfunction

  function automatic sample_t pick_extreme();
    case ($urandom_range(4))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // New random register settings; unused bits of the data carry noise.
  task automatic randomize_config();
    wait_drained();
    write_reg(cpid_pkg::REG_OUTER_KP, {16'($urandom()), pick_gain()});
    write_reg(cpid_pkg::REG_OUTER_KI, {16'($urandom()), pick_gain()});
    write_reg(cpid_pkg::REG_OUTER_KD, {16'($urandom()), pick_gain()});
    write_reg(cpid_pkg::REG_INNER_KP, {16'($urandom()), pick_gain()});
    write_reg(cpid_pkg::REG_INNER_KI, {16'($urandom()), pick_gain()});
    write_reg(cpid_pkg::REG_INNER_KD, {16'($urandom()), pick_gain()});
    write_reg(cpid_pkg::REG_INTEGRAL_LIMIT, {9'($urandom()), pick_limit()});
    write_reg(cpid_pkg::REG_LOOP_MODE, {31'($urandom()), 1'($urandom())});
    if ($urandom_range(2) == 0)
      write_reg(cpid_pkg::CFG_IDX_W'($urandom_range(15, int'(cpid_pkg::REG_LOOP_MODE) + 1)),
                $urandom());
  endtask

  // Mostly a set point that drifts with measurements near it, plus noise and extremes.
  task automatic random_ticks(input int count);
    sample_t im;
    sample_t om;
    sample_t ot;
    int style;
    for (int i = 0; i < count; i++) begin
      style = $urandom_range(9);
      if (style < 6) begin
        track_sp = int'(sat_sample(track_sp + int'($urandom_range(100)) - 50));
        ot = sat_sample(track_sp);
        om = sat_sample(track_sp + int'($urandom_range(400)) - 200);
        im = sat_sample(int'(om) + int'($urandom_range(64)) - 32);
      end else if (style < 8) begin
        im = SAMPLE_BITS'($urandom());
        om = SAMPLE_BITS'($urandom());
        ot = SAMPLE_BITS'($urandom());
      end else begin
        im = pick_extreme();
        om = pick_extreme();
        ot = pick_extreme();
        if (style == 9) track_sp = int'(sample_t'($urandom()));
      end
      send_tick(im, om, ot);
    end
  endtask

  // Ticks under the reset settings: zero gains, limit 2000, cascade.
  task automatic test_reset_defaults();
    send_tick(16'sd100, 16'sd500, -16'sd300);
    send_tick(-16'sd1, 16'sd32767, -16'sd32768);
    send_tick(16'sd0, 16'sd0, 16'sd0);
  endtask

  // Field extremes, both modes, ignored register indexes and a zero limit.
  task automatic test_directed();
    wait_drained();
    write_reg(cpid_pkg::REG_OUTER_KP, 32'd1);
    write_reg(cpid_pkg::REG_OUTER_KI, 32'd1);
    write_reg(cpid_pkg::REG_OUTER_KD, 32'd1);
    write_reg(cpid_pkg::REG_INNER_KP, 32'd1);
    write_reg(cpid_pkg::REG_INNER_KI, 32'd0);
    write_reg(cpid_pkg::REG_INNER_KD, 32'd1);
    write_reg(cpid_pkg::REG_INTEGRAL_LIMIT, 32'd2000);
    write_reg(cpid_pkg::REG_LOOP_MODE, 32'(cpid_pkg::MODE_CASCADE));
    send_tick(16'sd0, 16'sd0, 16'sd0);
    send_tick(16'sd32767, 16'sd32767, -16'sd32768);
    send_tick(-16'sd32768, -16'sd32768, 16'sd32767);
    send_tick(16'sd0, -16'sd1, 16'sd0);
    send_tick(16'sd1, 16'sd0, 16'sd1);

    // Full-scale gains and the widest limit drive both outputs into saturation.
    wait_drained();
    write_reg(cpid_pkg::REG_OUTER_KP, 32'hFFFF_FFFF);
    write_reg(cpid_pkg::REG_OUTER_KI, 32'hFFFF_FFFF);
    write_reg(cpid_pkg::REG_OUTER_KD, 32'hFFFF_FFFF);
    write_reg(cpid_pkg::REG_INNER_KP, 32'hFFFF_FFFF);
    write_reg(cpid_pkg::REG_INNER_KI, 32'hFFFF_FFFF);
    write_reg(cpid_pkg::REG_INNER_KD, 32'hFFFF_FFFF);
    write_reg(cpid_pkg::REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF);
    send_tick(16'sd32767, -16'sd32768, 16'sd32767);
    send_tick(-16'sd32768, 16'sd32767, -16'sd32768);
    send_tick(16'sd32767, 16'sd32767, -16'sd32768);

    // Single loop: the inner measurement must not matter.
    wait_drained();
    write_reg(cpid_pkg::REG_OUTER_KP, 32'd3);
    write_reg(cpid_pkg::REG_OUTER_KI, 32'd2);
    write_reg(cpid_pkg::REG_OUTER_KD, 32'd1);
    write_reg(cpid_pkg::REG_LOOP_MODE, 32'hFFFF_FFFE);
    send_tick(16'sd32767, 16'sd100, 16'sd0);
    send_tick(-16'sd32768, 16'sd100, 16'sd0);
    send_tick(16'sd0, -16'sd5, 16'sd5);

    // Writes to unused indexes change nothing.
    wait_drained();
    write_reg(cpid_pkg::CFG_IDX_W'(int'(cpid_pkg::REG_LOOP_MODE) + 1), 32'hFFFF_FFFF);
    write_reg('1, 32'hFFFF_FFFF);
    send_tick(16'sd7, 16'sd20, 16'sd10);
    send_tick(16'sd7, 16'sd20, 16'sd10);

    // A zero limit holds the integral at or below zero, back in cascade.
    wait_drained();
    write_reg(cpid_pkg::REG_INTEGRAL_LIMIT, 32'hFF80_0000);
    write_reg(cpid_pkg::REG_OUTER_KI, 32'd3);
    write_reg(cpid_pkg::REG_LOOP_MODE, 32'(cpid_pkg::MODE_CASCADE));
    send_tick(16'sd5, 16'sd100, 16'sd0);
    send_tick(16'sd5, -16'sd100, 16'sd0);
    send_tick(16'sd5, -16'sd32768, 16'sd32767);
  endtask

  // Long runs of large errors of one sign push both integrals to their floor and ceiling.
  task automatic test_integral_saturation();
    sample_t lo_end;
    sample_t hi_end;
    lo_end = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    hi_end = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    wait_drained();
    write_reg(cpid_pkg::REG_OUTER_KP, 32'd0);
    write_reg(cpid_pkg::REG_OUTER_KI, 32'd1);
    write_reg(cpid_pkg::REG_OUTER_KD, 32'd0);
    write_reg(cpid_pkg::REG_INNER_KP, 32'd0);
    write_reg(cpid_pkg::REG_INNER_KI, 32'd1);
    write_reg(cpid_pkg::REG_INNER_KD, 32'd2);
    write_reg(cpid_pkg::REG_INTEGRAL_LIMIT, 32'h007F_FFFF);
    write_reg(cpid_pkg::REG_LOOP_MODE, 32'(cpid_pkg::MODE_CASCADE));
    for (int i = 0; i < 140; i++) begin
      send_tick(sat_sample(int'(lo_end) + int'($urandom_range(20))),
                sat_sample(int'(lo_end) + int'($urandom_range(20))),
                sat_sample(int'(hi_end) - int'($urandom_range(20))));
    end
    for (int i = 0; i < 140; i++) begin
      send_tick(sat_sample(int'(hi_end) - int'($urandom_range(20))),
                sat_sample(int'(hi_end) - int'($urandom_range(20))),
                sat_sample(int'(lo_end) + int'($urandom_range(20))));
    end
  endtask

  // The sender holds off until every word is back, then resumes with the same settings.
  task automatic test_pause_drain();
    random_ticks(30);
    wait_drained();
    random_ticks(30);
  endtask

  task automatic test_random(input int chunks);
    for (int c = 0; c < chunks; c++) begin
      randomize_config();
      random_ticks(150);
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.inner_measured = '0;
    in_ch.outer_measured = '0;
    in_ch.outer_target   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    mismatches           = 0;
    cycle_count          = 0;
    track_sp             = 0;
    send_idle_pct        = 15;
    recv_idle_pct        = 56;

    shadow_cfg                = '0;
    shadow_cfg.integral_limit = cpid_pkg::LIMIT_RESET;
    shadow_cfg.loop_mode      = cpid_pkg::MODE_CASCADE;
    outer_st                  = '{prev_err: '0, integ: '0};
    inner_st                  = '{prev_err: '0, integ: '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles rarely, receiver often.
    test_reset_defaults();
    test_directed();
    test_random(3);

    // Sender idles often, receiver rarely.
    send_idle_pct = 56;
    recv_idle_pct = 15;
    test_integral_saturation();
    test_random(3);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_pause_drain();
    test_random(3);

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
